@@ src/lfu_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the LFU table.
package lfu_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int KEY_W          = 32;
	localparam int VAL_W          = 32;
	localparam int CAP_W          = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [VAL_W-1:0] DATA_MISS = '1;
	localparam logic             OP_GET    = 1'b0;
	localparam logic             OP_PUT    = 1'b1;

	// table update applied once the scan is done
	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_TOUCH    = 3'd1,
		ACT_TOUCH_WR = 3'd2,
		ACT_EVICT    = 3'd3,
		ACT_INSERT   = 3'd4
	} act_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic update;
		act_t act;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic is_put;
		logic cap_zero;
		logic full;
		logic match;
		logic vic_found;
		logic free_found;
	} sts_t;

endpackage

@@ src/lfu_cache_table_top.sv @@
// Top level of the LFU key-value table with LRU tie-break.
// Raise start with op/key/value while busy is low; the word is taken on that edge.
// The table is scanned one entry per cycle through the key/value memories; an item
// passes the scan, then a drain state for the read stage, then the update state,
// and then the cycle with done high, in which a new start is already taken.
// done is registered from the update state and stays high for exactly one cycle.
// The receiver cannot stall: sample hit, data, evicted and evicted_key whenever
// done is high. Write capacity through cfg_we and cfg_wdata only while the table
// is idle; values above ENTRIES act as ENTRIES.
module lfu_cache_table_top import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    start,
	output logic                    busy,
	input  logic                    op,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic                    hit,
	output logic signed [VAL_W-1:0] data,
	output logic                    evicted,
	output logic [KEY_W-1:0]        evicted_key
);

	cmd_t cmd;
	sts_t sts;

	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lfu_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.key         (key),
		.value       (value),
		.hit         (hit),
		.data        (data),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

@@ src/lfu_ctrl.sv @@
// Sequencer for the LFU table: accept, scan, drain, update, result strobe.
module lfu_ctrl import lfu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;
	act_t   act;

	always_comb begin
		if (!sts.is_put) begin
			act = sts.match ? ACT_TOUCH : ACT_NONE;
		end else if (sts.cap_zero) begin
			act = ACT_NONE;
		end else if (sts.match) begin
			act = ACT_TOUCH_WR;
		end else if (sts.full && sts.vic_found) begin
			act = ACT_EVICT;
		end else if (sts.free_found) begin
			act = ACT_INSERT;
		end else begin
			act = ACT_NONE;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.update = 1'b0;
		cmd.act    = act;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.update;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

@@ src/lfu_dp.sv @@
// Datapath of the LFU table: key/value memories, per-entry counters, scan and update.
module lfu_dp import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    op,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    hit,
	output logic signed [VAL_W-1:0] data,
	output logic                    evicted,
	output logic [KEY_W-1:0]        evicted_key
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// storage
	logic [KEY_W-1:0]      key_mem [ENTRIES];
	logic [VAL_W-1:0]      val_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [COUNT_BITS-1:0] count_q [ENTRIES];
	logic [RANK_W-1:0]     rank_q  [ENTRIES];
	logic [OCC_W-1:0]      occ_q;
	logic [CAP_W-1:0]      capacity_q;

	// latched word
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// scan
	logic [IDX_W-1:0] cnt_q;
	logic             sv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [VAL_W-1:0] val_rd_s1;

	// search results
	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic [RANK_W-1:0]     match_rank_q;
	logic [VAL_W-1:0]      match_val_q;
	logic                  vic_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [RANK_W-1:0]     vic_rank_q;
	logic [COUNT_BITS-1:0] vic_count_q;
	logic [KEY_W-1:0]      vic_key_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// result registers
	logic             hit_q;
	logic [VAL_W-1:0] data_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evk_q;

	logic                  cur_valid;
	logic [COUNT_BITS-1:0] cur_count;
	logic [RANK_W-1:0]     cur_rank;
	logic                  better;
	logic [CMP_W-1:0]      cap_ext, cap_eff, occ_ext;
	logic [IDX_W-1:0]      ins_idx;

	assign cur_valid = valid_q[idx_s1];
	assign cur_count = count_q[idx_s1];
	assign cur_rank  = rank_q[idx_s1];

	// lower count wins; on a tie the older entry (higher rank) wins
	assign better = !vic_q || (cur_count < vic_count_q) ||
		((cur_count == vic_count_q) && (cur_rank > vic_rank_q));

	assign cap_ext = CMP_W'(capacity_q);
	assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
	assign occ_ext = CMP_W'(occ_q);
	assign ins_idx = (cmd.act == ACT_EVICT) ? vic_idx_q : free_idx_q;

	always_comb begin
		sts.last       = (cnt_q == IDX_W'(ENTRIES - 1));
		sts.is_put     = (op_q == OP_PUT);
		sts.cap_zero   = (cap_eff == '0);
		sts.full       = (occ_ext >= cap_eff);
		sts.match      = match_q;
		sts.vic_found  = vic_q;
		sts.free_found = free_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// memories: one read address (scan counter), one write address (update)
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			key_rd_s1 <= key_mem[cnt_q];
			val_rd_s1 <= val_mem[cnt_q];
		end
		if (cmd.update) begin
			unique case (cmd.act)
				ACT_TOUCH_WR: begin
					val_mem[match_idx_q] <= val_q;
				end
				ACT_EVICT, ACT_INSERT: begin
					key_mem[ins_idx] <= key_q;
					val_mem[ins_idx] <= val_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sv_s1 <= 1'b0;
		end else begin
			sv_s1 <= cmd.issue;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) idx_s1 <= cnt_q;
		if (cmd.load) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value;
		end
	end

	// search accumulators: match, victim and first free slot in one pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			vic_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			vic_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (sv_s1) begin
			if (cur_valid && (key_rd_s1 == key_q) && !match_q) match_q <= 1'b1;
			if (cur_valid && better) vic_q <= 1'b1;
			if (!cur_valid && !free_q) free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_s1) begin
			if (cur_valid && (key_rd_s1 == key_q) && !match_q) begin
				match_idx_q  <= idx_s1;
				match_rank_q <= cur_rank;
				match_val_q  <= val_rd_s1;
			end
			if (cur_valid && better) begin
				vic_idx_q   <= idx_s1;
				vic_rank_q  <= cur_rank;
				vic_count_q <= cur_count;
				vic_key_q   <= key_rd_s1;
			end
			if (!cur_valid && !free_q) free_idx_q <= idx_s1;
		end
	end

	// per-entry update of valid, counts and recency ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.update && (cmd.act == ACT_INSERT)) begin
			valid_q[free_idx_q] <= 1'b1;
			occ_q               <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				unique case (cmd.act)
					ACT_TOUCH, ACT_TOUCH_WR: begin
						if (IDX_W'(i) == match_idx_q) begin
							rank_q[i] <= '0;
							if (count_q[i] != '1) count_q[i] <= count_q[i] + 1'b1;
						end else if (valid_q[i] && (rank_q[i] < match_rank_q)) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					ACT_EVICT: begin
						if (IDX_W'(i) == vic_idx_q) begin
							rank_q[i]  <= '0;
							count_q[i] <= COUNT_BITS'(1);
						end else if (valid_q[i] && !(rank_q[i] > vic_rank_q)) begin
							// entries newer than the victim age by one; older ones
							// close the gap and age, so they keep their rank
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					ACT_INSERT: begin
						if (IDX_W'(i) == free_idx_q) begin
							rank_q[i]  <= '0;
							count_q[i] <= COUNT_BITS'(1);
						end else if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q     <= match_q;
			evicted_q <= (cmd.act == ACT_EVICT);
			evk_q     <= (cmd.act == ACT_EVICT) ? vic_key_q : '0;
			if (op_q == OP_GET) begin
				data_q <= match_q ? match_val_q : DATA_MISS;
			end else begin
				data_q <= '0;
			end
		end
	end

	assign hit         = hit_q;
	assign data        = data_q;
	assign evicted     = evicted_q;
	assign evicted_key = evk_q;

endmodule
